### hdl/sorted_software_timer_queue_unit_defines.svh
`ifndef SORTED_SOFTWARE_TIMER_QUEUE_UNIT_DEFINES_SVH
`define SORTED_SOFTWARE_TIMER_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define STQ_ASSERT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/stq_pkg.sv
`timescale 1ns / 1ps
package stq_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int SLOT_W    = 4;
  localparam int DL_W      = 32;
  localparam int TAG_W     = 32;
  localparam int DEST_W    = 4;
  localparam int FUNC_W    = 2;
  localparam int CNT_W     = 5;
  localparam int TS_W      = 5;
  localparam int MAX_OUT   = 16;
  localparam int Q_DEPTH   = 2;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;

  localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_EXP = 1'b1;

  localparam logic [TS_W-1:0] TASK_SLOT_RST = 5'd16;
  localparam logic            REG_TASK_SLOT = 1'b0;

  typedef enum logic [1:0] {OP_SET, OP_CANCEL, OP_TICK, OP_NOP} op_t;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [DL_W-1:0]   delay;
    logic [DEST_W-1:0] dest;
    logic [TAG_W-1:0]  tag;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_out_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [DL_W-1:0]   dl;
    logic [TAG_W-1:0]  tag;
    logic [DEST_W-1:0] dest;
  } ent_t;

endpackage

### hdl/stq_front.sv
`timescale 1ns / 1ps
module stq_front #(
  parameter int SLOTS = stq_pkg::SLOTS_DEF
) (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [stq_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [stq_pkg::FUNC_W-1:0]     in_tuser,
  input  logic                           q_full,
  output logic                           push,
  output stq_pkg::cmd_t                  push_cmd
);

  logic slot_ok;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;
  assign slot_ok   = int'(in_tdata[3:0]) < SLOTS;

  // Sets and cancels with out-of-range slots, and unused codes, become no-ops that only acknowledge.
  always_comb begin
    push_cmd.slot  = in_tdata[3:0];
    push_cmd.delay = in_tdata[35:4];
    push_cmd.dest  = in_tdata[39:36];
    push_cmd.tag   = in_tdata[71:40];
    unique case (in_tuser)
      stq_pkg::FUNC_SET:    push_cmd.op = slot_ok ? stq_pkg::OP_SET : stq_pkg::OP_NOP;
      stq_pkg::FUNC_CANCEL: push_cmd.op = slot_ok ? stq_pkg::OP_CANCEL : stq_pkg::OP_NOP;
      stq_pkg::FUNC_TICK:   push_cmd.op = stq_pkg::OP_TICK;
      default:              push_cmd.op = stq_pkg::OP_NOP;
    endcase
  end

endmodule

### hdl/stq_cmd_fifo.sv
`timescale 1ns / 1ps
module stq_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  stq_pkg::cmd_t   push_cmd,
  output logic            full,
  input  logic            pop,
  output stq_pkg::q_out_t head
);

  localparam int D  = stq_pkg::Q_DEPTH;
  localparam int AW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  stq_pkg::cmd_t  mem_r [D];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full       = cnt_r == CW'(D);
  assign head.valid = cnt_r != '0;
  assign head.cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(D - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(D - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### hdl/stq_back.sv
`timescale 1ns / 1ps
module stq_back #(
  parameter int SLOTS = stq_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  stq_pkg::q_out_t                head,
  output logic                           pop,
  input  logic [stq_pkg::TS_W-1:0]       task_slot,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [stq_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser,
  output logic                           out_tlast
);

  localparam int LW = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REMOVE = 3'd1;
  localparam logic [2:0] S_INSERT = 3'd2;
  localparam logic [2:0] S_ACK    = 3'd3;
  localparam logic [2:0] S_COUNT  = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]                 state_r, state_nxt;
  stq_pkg::cmd_t              cmd_r;
  logic [stq_pkg::DL_W-1:0]   tick_r, tick_nxt;
  logic [stq_pkg::DL_W-1:0]   dl_r;
  logic [LW-1:0]              len_r, len_nxt;
  logic [LW-1:0]              fin_r;
  stq_pkg::cnt_t              left_r, left_nxt;

  // Sorted row of entries, head at index 0; valid entries form a prefix.
  stq_pkg::ent_t              ent_r   [SLOTS];
  stq_pkg::ent_t              ent_nxt [SLOTS];
  logic [SLOTS-1:0]           ev_r, ev_nxt;

  logic [SLOTS-1:0]           match, past, gt, first, expd, bnd, sh;
  logic [LW-1:0]              k;
  stq_pkg::cnt_t              emit_n;
  stq_pkg::ent_t              new_ent;
  logic                       out_free, do_shift, do_insert;

  logic                       out_vld_r;
  logic                       kind_r, sw_r, last_r;
  logic [stq_pkg::SLOT_W-1:0] oslot_r;
  logic [stq_pkg::TAG_W-1:0]  otag_r;
  logic [stq_pkg::DEST_W-1:0] odest_r;
  stq_pkg::cnt_t              ocnt_r;

  assign out_free = !out_vld_r || out_tready;
  assign pop      = (state_r == S_IDLE) && head.valid;

  assign new_ent.slot = cmd_r.slot;
  assign new_ent.dl   = dl_r;
  assign new_ent.tag  = cmd_r.tag;
  assign new_ent.dest = cmd_r.dest;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = ev_r[i] && (ent_r[i].slot == cmd_r.slot);
      past[i]  = |(match & ({SLOTS{1'b1}} >> (SLOTS - 1 - i)));
      gt[i]    = !ev_r[i] || (ent_r[i].dl > dl_r);
      expd[i]  = ev_r[i] && (ent_r[i].dl <= tick_r);
    end
    first[0] = gt[0];
    for (int i = 1; i < SLOTS; i++) begin
      first[i] = gt[i] && !gt[i-1];
    end
    for (int i = 0; i < SLOTS - 1; i++) begin
      bnd[i] = expd[i] && !expd[i+1];
    end
    bnd[SLOTS-1] = expd[SLOTS-1];
    // The expired entries are a prefix, so its end gives their number.
    k = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (bnd[i]) begin
        k = k | LW'(i + 1);
      end
    end
    emit_n = (int'(k) > stq_pkg::MAX_OUT) ? stq_pkg::cnt_t'(stq_pkg::MAX_OUT)
                                          : stq_pkg::cnt_t'(k);
  end

  assign do_shift  = (state_r == S_REMOVE) || ((state_r == S_EMIT) && out_free);
  assign do_insert = state_r == S_INSERT;
  assign sh        = (state_r == S_EMIT) ? {SLOTS{1'b1}} : past;

  always_comb begin
    ev_nxt = ev_r;
    for (int i = 0; i < SLOTS; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    if (do_shift) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        if (sh[i]) begin
          ent_nxt[i] = ent_r[i+1];
          ev_nxt[i]  = ev_r[i+1];
        end
      end
      if (sh[SLOTS-1]) begin
        ev_nxt[SLOTS-1] = 1'b0;
      end
    end
    if (do_insert) begin
      // New entry goes after every entry with an equal or earlier deadline.
      if (first[0]) begin
        ent_nxt[0] = new_ent;
        ev_nxt[0]  = 1'b1;
      end
      for (int i = 1; i < SLOTS; i++) begin
        if (first[i]) begin
          ent_nxt[i] = new_ent;
          ev_nxt[i]  = 1'b1;
        end else if (gt[i]) begin
          ent_nxt[i] = ent_r[i-1];
          ev_nxt[i]  = ev_r[i-1];
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    tick_nxt  = tick_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          unique case (head.cmd.op)
            stq_pkg::OP_SET, stq_pkg::OP_CANCEL: state_nxt = S_REMOVE;
            stq_pkg::OP_TICK: begin
              tick_nxt  = tick_r + 1'b1;
              state_nxt = S_COUNT;
            end
            default: state_nxt = S_ACK;
          endcase
        end
      end
      S_REMOVE: begin
        if (|match) begin
          len_nxt = len_r - 1'b1;
        end
        state_nxt = (cmd_r.op == stq_pkg::OP_SET) ? S_INSERT : S_ACK;
      end
      S_INSERT: begin
        len_nxt   = len_r + 1'b1;
        state_nxt = S_ACK;
      end
      S_ACK: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_COUNT: begin
        left_nxt  = emit_n;
        state_nxt = (emit_n == '0) ? S_ACK : S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          len_nxt  = len_r - 1'b1;
          left_nxt = left_r - 1'b1;
          if (left_r == stq_pkg::cnt_t'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      tick_r    <= '0;
      len_r     <= '0;
      left_r    <= '0;
      ev_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      ev_r    <= ev_nxt;
      if ((state_r == S_ACK || state_r == S_EMIT) && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
    if (pop) begin
      cmd_r <= head.cmd;
    end
    if (state_r == S_REMOVE) begin
      dl_r <= tick_r + cmd_r.delay;
    end
    if (state_r == S_COUNT) begin
      fin_r <= len_r - LW'(emit_n);
    end
    if (state_r == S_ACK && out_free) begin
      kind_r  <= stq_pkg::KIND_ACK;
      oslot_r <= '0;
      otag_r  <= '0;
      odest_r <= '0;
      sw_r    <= 1'b0;
      ocnt_r  <= stq_pkg::cnt_t'(len_r);
      last_r  <= 1'b1;
    end else if (state_r == S_EMIT && out_free) begin
      kind_r  <= stq_pkg::KIND_EXP;
      oslot_r <= ent_r[0].slot;
      otag_r  <= ent_r[0].tag;
      odest_r <= ent_r[0].dest;
      sw_r    <= task_slot == {1'b0, ent_r[0].slot};
      ocnt_r  <= stq_pkg::cnt_t'(fin_r);
      last_r  <= left_r == stq_pkg::cnt_t'(1);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {2'b00, ocnt_r, sw_r, odest_r, otag_r, oslot_r};

endmodule

### hdl/sorted_software_timer_queue_unit.sv
`timescale 1ns / 1ps
`include "sorted_software_timer_queue_unit_defines.svh"
// Sorted timer expiry list. Commands enter through a two-entry queue and are
// executed by a sequencer that keeps the armed timers in a row of entries
// sorted by deadline, each entry comparing its own deadline in parallel.
// A set passes through the sequencer steps dequeue, remove, insert and acknowledge;
// a cancel skips the insert and a no-op goes from dequeue straight to acknowledge.
// A tick counts the expired timers, then acknowledges if none expired, or else emits
// one expiry per expired timer (up to 16), each taken from the head of the row.
// The result register holds one transaction, so the next command is dequeued
// while the last result still waits for the consumer.
module sorted_software_timer_queue_unit #(
  parameter int SLOTS = stq_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // timer_slot[3:0], delay[35:4], dest_queue[39:36], tag[71:40]
  input  logic [stq_pkg::IN_DATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [stq_pkg::FUNC_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // exp_slot[3:0], exp_tag[35:4], exp_dest[39:36], switch_task[40],
  // active_count[45:41], zero fill[47:46]
  output logic [stq_pkg::OUT_DATA_W-1:0] out_tdata,
  // kind[0]
  output logic                           out_tuser,
  output logic                           out_tlast,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [2:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  logic                     q_full, push, pop;
  stq_pkg::cmd_t            push_cmd;
  stq_pkg::q_out_t          head;
  logic [stq_pkg::TS_W-1:0] task_slot_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == stq_pkg::REG_TASK_SLOT)
                      ? {27'd0, task_slot_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_slot_r <= stq_pkg::TASK_SLOT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == stq_pkg::REG_TASK_SLOT) begin
      task_slot_r <= cfg_pwdata[stq_pkg::TS_W-1:0];
    end
  end

  stq_front #(.SLOTS(SLOTS)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  stq_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  stq_back #(.SLOTS(SLOTS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .task_slot  (task_slot_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `STQ_ASSERT(ack_ends_item, out_tvalid && !out_tuser, out_tlast, "ack without tlast")
  `STQ_ASSERT(ack_clean, out_tvalid && !out_tuser, out_tdata[40:0] == '0, "ack not zero")
  `STQ_ASSERT_NEXT(burst_follows, out_tvalid && out_tready && !out_tlast, out_tvalid && out_tuser, "burst")

endmodule

### bench/sorted_software_timer_queue_unit_test.sv
`timescale 1ns / 1ps
module sorted_software_timer_queue_unit_test;

  localparam logic [stq_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_TASK_SLOT = 3'd0;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic                      kind;
    logic [3:0]                slot;
    logic [31:0]               tag;
    logic [3:0]                dest;
    logic                      sw;
    logic [stq_pkg::CNT_W-1:0] active;
    logic                      last;
  } timer_result_t;

  typedef struct {
    logic [1:0]                func;
    logic [3:0]                slot;
    logic [31:0]               delay;
    logic [3:0]                dest;
    logic [31:0]               tag;
    bit                        typed;
    logic                      ekind;
    logic [stq_pkg::CNT_W-1:0] ecnt;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [stq_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [stq_pkg::FUNC_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [stq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  always #4 clk = ~clk;

  sorted_software_timer_queue_unit dut (.*);

  // Shadow timer state.
  logic [31:0] now_ticks;
  logic [31:0] due_at [16];
  logic [31:0] slot_tag [16];
  logic [3:0] slot_dest [16];
  int unsigned by_deadline[$];
  logic [stq_pkg::TS_W-1:0] switch_slot;

  timer_result_t pending[$];
  int errors = 0;
  int accepted = 0;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void unlist(int unsigned s);
    for (int i = 0; i < by_deadline.size(); i++)
      if (by_deadline[i] == s) begin
        by_deadline.delete(i);
        return;
      end
  endfunction

  // Applies one transaction to the shadow state; returns its results in order.
  function automatic void timer_outcome(logic [1:0] func, logic [3:0] slot, logic [31:0] delay,
                                        logic [3:0] dest, logic [31:0] tag,
                                        ref timer_result_t res[$]);
    int p;
    timer_result_t r;
    res = {};
    if (func == stq_pkg::FUNC_SET) begin
      unlist(slot);
      due_at[slot] = now_ticks + delay;
      slot_tag[slot] = tag;
      slot_dest[slot] = dest;
      p = 0;
      while (p < by_deadline.size() && due_at[by_deadline[p]] <= due_at[slot]) p++;
      by_deadline.insert(p, slot);
    end else if (func == stq_pkg::FUNC_CANCEL) begin
      unlist(slot);
    end else if (func == stq_pkg::FUNC_TICK) begin
      now_ticks = now_ticks + 1;
      while (by_deadline.size() > 0 && res.size() < stq_pkg::MAX_OUT &&
             due_at[by_deadline[0]] <= now_ticks) begin
        p = by_deadline.pop_front();
        r.kind = stq_pkg::KIND_EXP;
        r.slot = 4'(p);
        r.tag = slot_tag[p];
        r.dest = slot_dest[p];
        r.sw = (p == switch_slot);
        r.last = 1'b0;
        res.push_back(r);
      end
    end
    if (res.size() == 0) begin
      r = '{stq_pkg::KIND_ACK, 4'd0, 32'd0, 4'd0, 1'b0, '0, 1'b0};
      res.push_back(r);
    end
    foreach (res[k]) res[k].active = stq_pkg::CNT_W'(by_deadline.size());
    res[res.size() - 1].last = 1'b1;
  endfunction

  bit keep_valid = 1'b0;

  task automatic send(logic [1:0] func, logic [3:0] slot, logic [31:0] delay,
                      logic [3:0] dest, logic [31:0] tag, bit typed = 0,
                      logic ekind = 0, logic [stq_pkg::CNT_W-1:0] ecnt = 0);
    timer_result_t res[$];
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {tag, dest, delay, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    accepted++;
    timer_outcome(func, slot, delay, dest, tag, res);
    if (typed) begin
      res = {};
      res.push_back('{ekind, 4'd0, 32'd0, 4'd0, 1'b0, ecnt, 1'b1});
    end
    foreach (res[k]) pending.push_back(res[k]);
    // End of a burst: drop valid for a random gap.
    if (!keep_valid) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_task_slot(logic [stq_pkg::TS_W-1:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_TASK_SLOT;
    cfg_pwdata <= 32'(v);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[stq_pkg::TS_W-1:0] !== v) report("task_slot readback", cfg_prdata, v);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    switch_slot = v;
  endtask

  // Receiver: changes its stall pattern every so often, and once holds off for
  // a long stretch so the queue fills and the input stalls.
  int stall_mode = 0;
  int hold_left = 0;
  bit held = 1'b0;
  int cyc = 0;
  always @(negedge clk) begin
    cyc++;
    if (cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (!held && accepted >= 60) begin
      held = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (cyc % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    timer_result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending.size() == 0) begin
        report("unexpected transaction", out_tdata, 0);
      end else begin
        w = pending.pop_front();
        if (out_tuser !== w.kind) report("kind", out_tuser, w.kind);
        if (out_tdata[3:0] !== w.slot) report("exp_slot", out_tdata[3:0], w.slot);
        if (out_tdata[35:4] !== w.tag) report("exp_tag", out_tdata[35:4], w.tag);
        if (out_tdata[39:36] !== w.dest) report("exp_dest", out_tdata[39:36], w.dest);
        if (out_tdata[40] !== w.sw) report("switch_task", out_tdata[40], w.sw);
        if (out_tdata[45:41] !== w.active) report("active_count", out_tdata[45:41], w.active);
        if (out_tlast !== w.last) report("last", out_tlast, w.last);
      end
    end
  end

  initial begin
    #20ms;
    $display("sorted_software_timer_queue_unit_test NOT OK");
    $finish;
  end

  stim_row_t directed[] = '{
    '{stq_pkg::FUNC_TICK,   4'd0,  32'd0,        4'd0,  32'd0,        1, stq_pkg::KIND_ACK, 5'd0},
    '{stq_pkg::FUNC_CANCEL, 4'd5,  32'd0,        4'd0,  32'd0,        1, stq_pkg::KIND_ACK, 5'd0},
    '{FUNC_UNUSED,          4'd9,  32'h1234,     4'd2,  32'h77,       1, stq_pkg::KIND_ACK, 5'd0},
    '{stq_pkg::FUNC_SET,    4'd15, 32'hfffffff0, 4'd0,  32'd0,        1, stq_pkg::KIND_ACK, 5'd1},
    '{stq_pkg::FUNC_SET,    4'd0,  32'd1,        4'd15, 32'hffffffff, 1, stq_pkg::KIND_ACK, 5'd2},
    '{stq_pkg::FUNC_SET,    4'd3,  32'd2,        4'd3,  32'ha5a5a5a5, 1, stq_pkg::KIND_ACK, 5'd3},
    // Equal deadlines keep arrival order.
    '{stq_pkg::FUNC_SET,    4'd4,  32'd2,        4'd4,  32'h5a5a5a5a, 1, stq_pkg::KIND_ACK, 5'd4},
    // Re-arming moves the slot behind the others with the same deadline.
    '{stq_pkg::FUNC_SET,    4'd0,  32'd2,        4'd1,  32'h1111,     1, stq_pkg::KIND_ACK, 5'd4},
    '{stq_pkg::FUNC_TICK,   4'd0,  32'd0,        4'd0,  32'd0,        1, stq_pkg::KIND_ACK, 5'd4},
    '{stq_pkg::FUNC_TICK,   4'd0,  32'd0,        4'd0,  32'd0,        0, stq_pkg::KIND_ACK, 5'd0},
    '{stq_pkg::FUNC_SET,    4'd7,  32'd0,        4'd7,  32'hdead,     1, stq_pkg::KIND_ACK, 5'd2},
    '{stq_pkg::FUNC_CANCEL, 4'd15, 32'd0,        4'd0,  32'd0,        1, stq_pkg::KIND_ACK, 5'd1},
    '{stq_pkg::FUNC_CANCEL, 4'd15, 32'd0,        4'd0,  32'd0,        1, stq_pkg::KIND_ACK, 5'd1},
    '{stq_pkg::FUNC_TICK,   4'd0,  32'd0,        4'd0,  32'd0,        0, stq_pkg::KIND_ACK, 5'd0},
    // The deadline wraps past zero, so it is due on the next tick.
    '{stq_pkg::FUNC_SET,    4'd9,  32'hfffffffe, 4'd9,  32'hbeef,     1, stq_pkg::KIND_ACK, 5'd1},
    '{stq_pkg::FUNC_SET,    4'd10, 32'd0,        4'd10, 32'hcafe,     1, stq_pkg::KIND_ACK, 5'd2},
    '{stq_pkg::FUNC_TICK,   4'd0,  32'd0,        4'd0,  32'd0,        0, stq_pkg::KIND_ACK, 5'd0}
  };

  initial begin
    logic [stq_pkg::TS_W-1:0] phase_slot [4];
    int unsigned pick;
    logic [1:0] f;
    logic [31:0] d;
    phase_slot = '{5'd0, 5'd15, 5'd7, stq_pkg::TASK_SLOT_RST};
    now_ticks = '0;
    switch_slot = stq_pkg::TASK_SLOT_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed[i])
      send(directed[i].func, directed[i].slot, directed[i].delay, directed[i].dest,
           directed[i].tag, directed[i].typed, directed[i].ekind, directed[i].ecnt);
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_task_slot(phase_slot[ph]);
      for (int n = 0; n < 110; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) f = stq_pkg::FUNC_SET;
        else if (pick < 55) f = stq_pkg::FUNC_CANCEL;
        else if (pick < 96) f = stq_pkg::FUNC_TICK;
        else f = FUNC_UNUSED;
        d = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 24);
        keep_valid = ($urandom_range(0, 3) != 0);
        send(f, 4'($urandom_range(0, 15)), d, 4'($urandom_range(0, 15)), $urandom());
      end
      keep_valid = 1'b0;
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    wait_idle();
    if (errors == 0) begin
      $display("sorted_software_timer_queue_unit_test OK");
    end else begin
      $display("sorted_software_timer_queue_unit_test NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/stq_pkg.sv
hdl/stq_front.sv
hdl/stq_cmd_fifo.sv
hdl/stq_back.sv
hdl/sorted_software_timer_queue_unit.sv
bench/sorted_software_timer_queue_unit_test.sv
